// ----- sv/software_timer_table_core_defines.svh -----
// ----------------------------------------------------------------------------
// Software timer table assertion macros
// Shared helpers for the concurrent checks on the timer table ports.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_TABLE_CORE_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_CORE_DEFINES_SVH

// Check a property on every rising clock edge while out of reset.
`define STT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check a property on every rising clock edge, reset included.
`define STT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

// ----- sv/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// Software timer table package
// Sizes, codes and types shared by the timer table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stt_pkg;

  // Table geometry.
  localparam int SLOTS        = 8;
  localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W        = $clog2(SLOTS + 1);
  localparam int TAG_BITS     = 32;

  // Field widths.
  localparam int TIME_W       = 32;
  localparam int HANDLER_W    = 8;
  localparam int FIRED_SLOT_W = 3;

  // Request codes.
  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_UNUSED   = 2'd3
  } status_e;

  // Result kinds.
  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_FIRED  = 1'b1
  } kind_e;

  // Shared adder operations.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  // Slot store write operations.
  typedef enum logic [1:0] {
    WR_NONE     = 2'd0,
    WR_FULL     = 2'd1,
    WR_DEADLINE = 2'd2,
    WR_CLEAR    = 2'd3
  } wr_op_e;

  // One timer slot.
  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [HANDLER_W-1:0] handler;
    logic                 repeat_en;
    logic [TIME_W-1:0]    deadline;
    logic [TIME_W-1:0]    period;
  } slot_t;

  // Write port of the slot store.
  typedef struct packed {
    wr_op_e            op;
    logic [SLOT_W-1:0] idx;
    slot_t             data;
  } store_wr_t;

endpackage

// ----- sv/software_timer_table_core.sv -----
// ----------------------------------------------------------------------------
// Software timer table core
// Table of timer slots with add, remove and tick requests, run by a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge where start_i is high and busy_o is
//   low. action_i selects add, remove or tick; the other input fields carry
//   the tag, handler, period, repeat flag and tick time.
//   Results appear for one cycle with result_valid_o high and cannot be held
//   off. Add and remove give one status result. A tick gives one fired
//   result per due slot and then a status result; last_o marks the final one.
//   Datapath: the sequencer visits one slot per cycle through the single read
//   address of the slot store, with an extra step for each freed slot moved in
//   compaction and each fired slot in the scan; the one shared adder serves
//   arming, the due test and the reload. Add scans for a free slot and then
//   arms it, remove scans for the tag, and a tick compacts the table, then
//   scans it and closes with a status result. An unused action code gets a
//   reject status result straight from idle.
//   busy_o stays high until the last result is shown; the next request may be
//   taken in the cycle that shows it.
//   Reset frees all slots, clears the used count and the last tick time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module software_timer_table_core
  import stt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              action_i,
  input  logic [31:0]             task_tag_i,
  input  logic                    tag_present_i,
  input  logic [HANDLER_W-1:0]    handler_id_i,
  input  logic [TIME_W-1:0]       period_i,
  input  logic                    repeat_req_i,
  input  logic [TIME_W-1:0]       now_time_i,
  output logic                    result_valid_o,
  output logic                    kind_o,
  output logic [1:0]              status_o,
  output logic [HANDLER_W-1:0]    fired_handler_o,
  output logic [FIRED_SLOT_W-1:0] fired_slot_o,
  output logic                    last_o
);

  // Sequencer states.
  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_ADD_SCAN  = 8'b0000_0010,
    S_ADD_WRITE = 8'b0000_0100,
    S_REM_SCAN  = 8'b0000_1000,
    S_CMP_CHK   = 8'b0001_0000,
    S_CMP_MOVE  = 8'b0010_0000,
    S_SCAN      = 8'b0100_0000,
    S_UPD       = 8'b1000_0000
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     used_q, used_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [TIME_W-1:0]    last_tick_q, last_tick_d;

  // Captured request fields.
  logic [TAG_BITS-1:0]  tag_q, tag_d;
  logic                 present_q, present_d;
  logic [HANDLER_W-1:0] handler_q, handler_d;
  logic [TIME_W-1:0]    period_q, period_d;
  logic                 repeat_q, repeat_d;

  // Result registers.
  logic                    valid_q, valid_d;
  kind_e                   kind_q, kind_d;
  status_e                 status_q, status_d;
  logic [HANDLER_W-1:0]    fhandler_q, fhandler_d;
  logic [FIRED_SLOT_W-1:0] fslot_q, fslot_d;
  logic                    last_q, last_d;

  // Store and adder connections.
  logic [SLOT_W-1:0] rd_idx;
  slot_t             rd_data;
  store_wr_t         wr;
  alu_op_e           alu_op;
  logic [TIME_W-1:0] alu_a, alu_b, alu_res;

  logic             accept;
  logic             idx_lt_used;
  logic [CNT_W-1:0] tail;

  assign accept      = start_i && !busy_o;
  assign idx_lt_used = idx_q < used_q;
  assign tail        = used_q - CNT_W'(1);

  stt_slot_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .wr_i      (wr)
  );

  stt_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // Sequencer next-state and datapath control.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    used_d      = used_q;
    slot_d      = slot_q;
    last_tick_d = last_tick_q;
    tag_d       = tag_q;
    present_d   = present_q;
    handler_d   = handler_q;
    period_d    = period_q;
    repeat_d    = repeat_q;
    valid_d     = 1'b0;
    kind_d      = KIND_STATUS;
    status_d    = ST_OK;
    fhandler_d  = '0;
    fslot_d     = '0;
    last_d      = 1'b0;
    rd_idx      = idx_q[SLOT_W-1:0];
    wr.op       = WR_NONE;
    wr.idx      = idx_q[SLOT_W-1:0];
    wr.data     = rd_data;
    alu_op      = ALU_ADD;
    alu_a       = last_tick_q;
    alu_b       = period_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          tag_d     = (action_i == ACT_ADD && !tag_present_i) ? '0
                                                              : TAG_BITS'(task_tag_i);
          present_d = tag_present_i;
          handler_d = handler_id_i;
          period_d  = period_i;
          repeat_d  = repeat_req_i;
          idx_d     = '0;
          unique case (action_i)
            ACT_ADD:    state_d = S_ADD_SCAN;
            ACT_REMOVE: state_d = S_REM_SCAN;
            ACT_TICK: begin
              last_tick_d = now_time_i;
              state_d     = S_CMP_CHK;
            end
            default: begin
              valid_d  = 1'b1;
              last_d   = 1'b1;
              status_d = ST_REJECT;
            end
          endcase
        end
      end

      // Look for the first freed slot below the used count.
      S_ADD_SCAN: begin
        if (handler_q == '0) begin
          valid_d  = 1'b1;
          last_d   = 1'b1;
          status_d = ST_REJECT;
          state_d  = S_IDLE;
        end else if (idx_lt_used) begin
          if (rd_data.handler == '0) begin
            slot_d  = idx_q[SLOT_W-1:0];
            state_d = S_ADD_WRITE;
          end else begin
            idx_d = idx_q + CNT_W'(1);
          end
        end else if (used_q >= CNT_W'(SLOTS)) begin
          valid_d  = 1'b1;
          last_d   = 1'b1;
          status_d = ST_REJECT;
          state_d  = S_IDLE;
        end else begin
          slot_d  = used_q[SLOT_W-1:0];
          used_d  = used_q + CNT_W'(1);
          state_d = S_ADD_WRITE;
        end
      end

      // Arm the claimed slot at the last tick time plus the period.
      S_ADD_WRITE: begin
        wr.op             = WR_FULL;
        wr.idx            = slot_q;
        wr.data.tag       = tag_q;
        wr.data.handler   = handler_q;
        wr.data.repeat_en = repeat_q;
        wr.data.deadline  = alu_res;
        wr.data.period    = period_q;
        valid_d           = 1'b1;
        last_d            = 1'b1;
        status_d          = ST_OK;
        state_d           = S_IDLE;
      end

      // Free the first live slot with a matching tag.
      S_REM_SCAN: begin
        if (!present_q) begin
          valid_d  = 1'b1;
          last_d   = 1'b1;
          status_d = ST_REJECT;
          state_d  = S_IDLE;
        end else if (idx_lt_used) begin
          if (rd_data.handler != '0 && rd_data.tag == tag_q) begin
            wr.op    = WR_CLEAR;
            valid_d  = 1'b1;
            last_d   = 1'b1;
            status_d = ST_OK;
            state_d  = S_IDLE;
          end else begin
            idx_d = idx_q + CNT_W'(1);
          end
        end else begin
          valid_d  = 1'b1;
          last_d   = 1'b1;
          status_d = ST_NOTFOUND;
          state_d  = S_IDLE;
        end
      end

      // Compaction: step over live slots, fill each hole from the tail.
      S_CMP_CHK: begin
        if (idx_lt_used) begin
          if (rd_data.handler != '0) begin
            idx_d = idx_q + CNT_W'(1);
          end else begin
            state_d = S_CMP_MOVE;
          end
        end else begin
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end

      S_CMP_MOVE: begin
        rd_idx  = tail[SLOT_W-1:0];
        wr.op   = WR_FULL;
        used_d  = tail;
        state_d = S_CMP_CHK;
      end

      // Expiry scan: a slot is due when now minus deadline is not negative.
      S_SCAN: begin
        alu_op = ALU_SUB;
        alu_a  = last_tick_q;
        alu_b  = rd_data.deadline;
        if (idx_lt_used) begin
          if (rd_data.handler != '0 && !alu_res[TIME_W-1]) begin
            valid_d    = 1'b1;
            kind_d     = KIND_FIRED;
            fhandler_d = rd_data.handler;
            fslot_d    = FIRED_SLOT_W'(idx_q);
            state_d    = S_UPD;
          end else begin
            idx_d = idx_q + CNT_W'(1);
          end
        end else begin
          valid_d  = 1'b1;
          last_d   = 1'b1;
          status_d = ST_OK;
          state_d  = S_IDLE;
        end
      end

      // Reload a repeating slot, free a one-shot slot.
      S_UPD: begin
        alu_op = ALU_ADD;
        alu_a  = rd_data.deadline;
        alu_b  = rd_data.period;
        if (rd_data.repeat_en) begin
          wr.op            = WR_DEADLINE;
          wr.data.deadline = alu_res;
        end else begin
          wr.op = WR_CLEAR;
        end
        idx_d   = idx_q + CNT_W'(1);
        state_d = S_SCAN;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      used_q      <= '0;
      last_tick_q <= '0;
      valid_q     <= 1'b0;
      kind_q      <= KIND_STATUS;
      status_q    <= ST_OK;
      fhandler_q  <= '0;
      fslot_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      used_q      <= used_d;
      last_tick_q <= last_tick_d;
      valid_q     <= valid_d;
      kind_q      <= kind_d;
      status_q    <= status_d;
      fhandler_q  <= fhandler_d;
      fslot_q     <= fslot_d;
      last_q      <= last_d;
    end
  end

  // Captured request payload.
  always_ff @(posedge clk_i) begin
    slot_q    <= slot_d;
    tag_q     <= tag_d;
    present_q <= present_d;
    handler_q <= handler_d;
    period_q  <= period_d;
    repeat_q  <= repeat_d;
  end

  // Outputs.
  assign busy_o          = (state_q != S_IDLE);
  assign result_valid_o  = valid_q;
  assign kind_o          = kind_q;
  assign status_o        = status_q;
  assign fired_handler_o = fhandler_q;
  assign fired_slot_o    = fslot_q;
  assign last_o          = last_q;

endmodule

// ----- sv/stt_alu.sv -----
// ----------------------------------------------------------------------------
// Software timer table shared adder
// One 32-bit add/subtract unit used for arming, due checks and reloads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stt_alu
  import stt_pkg::*;
(
  input  alu_op_e           op_i,
  input  logic [TIME_W-1:0] a_i,
  input  logic [TIME_W-1:0] b_i,
  output logic [TIME_W-1:0] res_o
);

  logic [TIME_W-1:0] b_eff;

  // Subtraction is an add of the inverted operand with a carry in.
  assign b_eff = (op_i == ALU_SUB) ? ~b_i : b_i;
  assign res_o = a_i + b_eff + TIME_W'(op_i == ALU_SUB);

endmodule

// ----- sv/stt_slot_store.sv -----
// ----------------------------------------------------------------------------
// Software timer table slot store
// Register file of timer slots with one read address and one write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stt_slot_store
  import stt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SLOT_W-1:0] rd_idx_i,
  output slot_t             rd_data_o,
  input  store_wr_t         wr_i
);

  logic [TAG_BITS-1:0]  tag_q      [SLOTS];
  logic [HANDLER_W-1:0] handler_q  [SLOTS];
  logic                 repeat_q   [SLOTS];
  logic [TIME_W-1:0]    deadline_q [SLOTS];
  logic [TIME_W-1:0]    period_q   [SLOTS];

  // Handlers reset to zero, which marks every slot free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        handler_q[i] <= '0;
      end
    end else begin
      unique case (wr_i.op)
        WR_FULL:  handler_q[wr_i.idx] <= wr_i.data.handler;
        WR_CLEAR: handler_q[wr_i.idx] <= '0;
        default: ;
      endcase
    end
  end

  // The remaining slot fields are meaningful only once written.
  always_ff @(posedge clk_i) begin
    unique case (wr_i.op)
      WR_FULL: begin
        tag_q[wr_i.idx]      <= wr_i.data.tag;
        repeat_q[wr_i.idx]   <= wr_i.data.repeat_en;
        deadline_q[wr_i.idx] <= wr_i.data.deadline;
        period_q[wr_i.idx]   <= wr_i.data.period;
      end
      WR_DEADLINE: deadline_q[wr_i.idx] <= wr_i.data.deadline;
      default: ;
    endcase
  end

  // Single read address for all fields.
  assign rd_data_o.tag       = tag_q[rd_idx_i];
  assign rd_data_o.handler   = handler_q[rd_idx_i];
  assign rd_data_o.repeat_en = repeat_q[rd_idx_i];
  assign rd_data_o.deadline  = deadline_q[rd_idx_i];
  assign rd_data_o.period    = period_q[rd_idx_i];

endmodule

// ----- sv/stt_checker.sv -----
// ----------------------------------------------------------------------------
// Software timer table port checker
// Concurrent checks on the timer table ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "software_timer_table_core_defines.svh"

module stt_checker
  import stt_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start_i,
  input logic                    busy_o,
  input logic [1:0]              action_i,
  input logic                    result_valid_o,
  input logic                    kind_o,
  input logic [1:0]              status_o,
  input logic [HANDLER_W-1:0]    fired_handler_o,
  input logic [FIRED_SLOT_W-1:0] fired_slot_o,
  input logic                    last_o
);

  // A fired result is never the final one, carries status ok and a live handler.
  `STT_ASSERT(a_fired_shape,
    (result_valid_o && kind_o == KIND_FIRED) |->
      (!last_o && status_o == ST_OK && fired_handler_o != '0),
    "fired result malformed")

  // A status result always closes its request and carries no handler or slot.
  `STT_ASSERT(a_status_shape,
    (result_valid_o && kind_o == KIND_STATUS) |->
      (last_o && fired_handler_o == '0 && fired_slot_o == '0),
    "status result malformed")

  // The final result of a request is shown only once the block is free again.
  `STT_ASSERT(a_last_frees,
    (result_valid_o && last_o) |-> !busy_o,
    "busy while final result shown")

  // A real request keeps the block busy in the following cycle.
  `STT_ASSERT(a_take_busy,
    (start_i && !busy_o && action_i != ACT_NONE) |=> busy_o,
    "request did not start")

  // Nothing is reported after an edge that saw reset held.
  `STT_ASSERT_ALWAYS(a_reset_quiet,
    !rst_ni |=> !result_valid_o,
    "result during reset")

endmodule

bind software_timer_table_core stt_checker u_stt_checker (.*);

// ----- tb/timer_table_checker.sv -----
// ----------------------------------------------------------------------------
// Timer table result checker
// Watches the request and result ports of the timer table, keeps its own copy
// of the slot table, predicts the results of each accepted request and
// compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timer_table_checker
  import stt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_o,
  input  logic [1:0]              action_i,
  input  logic [31:0]             task_tag_i,
  input  logic                    tag_present_i,
  input  logic [HANDLER_W-1:0]    handler_id_i,
  input  logic [TIME_W-1:0]       period_i,
  input  logic                    repeat_req_i,
  input  logic [TIME_W-1:0]       now_time_i,
  input  logic                    result_valid_o,
  input  logic                    kind_o,
  input  logic [1:0]              status_o,
  input  logic [HANDLER_W-1:0]    fired_handler_o,
  input  logic [FIRED_SLOT_W-1:0] fired_slot_o,
  input  logic                    last_o,
  output int                      fail_count,
  output int                      pending_cnt
);

  typedef struct {
    kind_e                   kind;
    status_e                 status;
    logic [HANDLER_W-1:0]    handler;
    logic [FIRED_SLOT_W-1:0] slot;
    logic                    last;
  } timer_result_t;

  // Predicted slot table.
  logic [TAG_BITS-1:0]  tbl_tag      [SLOTS];
  logic [HANDLER_W-1:0] tbl_handler  [SLOTS];
  logic                 tbl_repeat   [SLOTS];
  logic [TIME_W-1:0]    tbl_deadline [SLOTS];
  logic [TIME_W-1:0]    tbl_period   [SLOTS];
  int                   tbl_used;
  logic [TIME_W-1:0]    tbl_last_tick;

  // Results still owed by the block, oldest first.
  timer_result_t owed_results[$];

  task automatic owe(kind_e kind, status_e status, logic [HANDLER_W-1:0] hdl,
                     int slot, logic last);
    timer_result_t r;
    r.kind    = kind;
    r.status  = status;
    r.handler = hdl;
    r.slot    = slot[FIRED_SLOT_W-1:0];
    r.last    = last;
    owed_results.push_back(r);
  endtask

  // Apply one accepted request to the table and queue the results it causes.
  task automatic apply_request(action_e act, logic [31:0] tag, logic present,
                               logic [HANDLER_W-1:0] hdl, logic [TIME_W-1:0] per,
                               logic rep, logic [TIME_W-1:0] now);
    status_e          st;
    int               idx;
    int               tail;
    logic [TIME_W-1:0] lag;
    st = ST_REJECT;
    case (act)
      ACT_ADD: begin
        if (hdl != '0) begin
          // Reuse the first freed slot, else grow at the tail.
          idx = -1;
          for (int i = 0; i < tbl_used; i++) begin
            if (idx < 0 && tbl_handler[i] == '0) idx = i;
          end
          if (idx < 0 && tbl_used < SLOTS) begin
            idx = tbl_used;
            tbl_used++;
          end
          if (idx >= 0) begin
            tbl_tag[idx]      = present ? tag : '0;
            tbl_period[idx]   = per;
            tbl_deadline[idx] = tbl_last_tick + per;
            tbl_repeat[idx]   = rep;
            tbl_handler[idx]  = hdl;
            st = ST_OK;
          end
        end
        owe(KIND_STATUS, st, '0, 0, 1'b1);
      end
      ACT_REMOVE: begin
        if (present) begin
          st = ST_NOTFOUND;
          for (int i = 0; i < tbl_used; i++) begin
            if (st == ST_NOTFOUND && tbl_handler[i] != '0 && tbl_tag[i] == tag) begin
              tbl_handler[i] = '0;
              st = ST_OK;
            end
          end
        end
        owe(KIND_STATUS, st, '0, 0, 1'b1);
      end
      ACT_TICK: begin
        tbl_last_tick = now;
        // Fill each hole with the tail slot.
        idx = 0;
        while (idx < tbl_used) begin
          if (tbl_handler[idx] != '0) begin
            idx++;
          end else begin
            tail = tbl_used - 1;
            tbl_tag[idx]      = tbl_tag[tail];
            tbl_handler[idx]  = tbl_handler[tail];
            tbl_repeat[idx]   = tbl_repeat[tail];
            tbl_deadline[idx] = tbl_deadline[tail];
            tbl_period[idx]   = tbl_period[tail];
            tbl_used = tail;
          end
        end
        // Expiry scan; a slot is due when now - deadline is not negative.
        for (int i = 0; i < tbl_used; i++) begin
          if (tbl_handler[i] != '0) begin
            lag = now - tbl_deadline[i];
            if (!lag[TIME_W-1]) begin
              owe(KIND_FIRED, ST_OK, tbl_handler[i], i, 1'b0);
              if (tbl_repeat[i]) tbl_deadline[i] = tbl_deadline[i] + tbl_period[i];
              else tbl_handler[i] = '0;
            end
          end
        end
        owe(KIND_STATUS, ST_OK, '0, 0, 1'b1);
      end
      default: begin
        owe(KIND_STATUS, ST_REJECT, '0, 0, 1'b1);
      end
    endcase
  endtask

  // Track requests and compare results on every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_tag[i]      = '0;
        tbl_handler[i]  = '0;
        tbl_repeat[i]   = 1'b0;
        tbl_deadline[i] = '0;
        tbl_period[i]   = '0;
      end
      tbl_used      = 0;
      tbl_last_tick = '0;
      owed_results.delete();
      fail_count    = 0;
      pending_cnt   = 0;
    end else begin
      if (start_i && !busy_o) begin
        apply_request(action_e'(action_i), task_tag_i, tag_present_i, handler_id_i,
                      period_i, repeat_req_i, now_time_i);
      end
      if (result_valid_o) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with none expected: kind %0d status %0d handler %0d slot %0d",
                   $time, kind_o, status_o, fired_handler_o, fired_slot_o);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (kind_o !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind_o);
            fail_count++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            fail_count++;
          end
          if (fired_handler_o !== want.handler) begin
            $display("%0t: handler expected %0d actual %0d", $time, want.handler,
                     fired_handler_o);
            fail_count++;
          end
          if (fired_slot_o !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, fired_slot_o);
            fail_count++;
          end
          if (last_o !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, last_o);
            fail_count++;
          end
        end
      end
      pending_cnt = owed_results.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Timer table testbench top
// Drives add, remove and tick requests into the timer table: a directed set
// covering field extremes, rejects, lookups that miss, a full table and time
// wrap, then random traffic in phases with and without gaps between requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import stt_pkg::*;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    start_i       = 1'b0;
  logic                    busy_o;
  logic [1:0]              action_i      = '0;
  logic [31:0]             task_tag_i    = '0;
  logic                    tag_present_i = 1'b0;
  logic [HANDLER_W-1:0]    handler_id_i  = '0;
  logic [TIME_W-1:0]       period_i      = '0;
  logic                    repeat_req_i  = 1'b0;
  logic [TIME_W-1:0]       now_time_i    = '0;
  logic                    result_valid_o;
  logic                    kind_o;
  logic [1:0]              status_o;
  logic [HANDLER_W-1:0]    fired_handler_o;
  logic [FIRED_SLOT_W-1:0] fired_slot_o;
  logic                    last_o;
  int                      fail_count;
  int                      pending_cnt;
  int                      gap_pct = 0;

  software_timer_table_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .action_i        (action_i),
    .task_tag_i      (task_tag_i),
    .tag_present_i   (tag_present_i),
    .handler_id_i    (handler_id_i),
    .period_i        (period_i),
    .repeat_req_i    (repeat_req_i),
    .now_time_i      (now_time_i),
    .result_valid_o  (result_valid_o),
    .kind_o          (kind_o),
    .status_o        (status_o),
    .fired_handler_o (fired_handler_o),
    .fired_slot_o    (fired_slot_o),
    .last_o          (last_o)
  );

  timer_table_checker checker_i (.*);

  always #1 clk_i = ~clk_i;

  // Hold one request until the block takes it, after an optional random gap.
  task automatic issue(action_e act, logic [31:0] tag, logic present,
                       logic [HANDLER_W-1:0] hdl, logic [TIME_W-1:0] per,
                       logic rep, logic [TIME_W-1:0] now);
    while ($urandom_range(99) < gap_pct) begin
      start_i       <= 1'b0;
      action_i      <= 2'($urandom_range(3));
      task_tag_i    <= $urandom();
      tag_present_i <= 1'($urandom_range(1));
      handler_id_i  <= 8'($urandom());
      period_i      <= $urandom();
      repeat_req_i  <= 1'($urandom_range(1));
      now_time_i    <= $urandom();
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    action_i      <= act;
    task_tag_i    <= tag;
    tag_present_i <= present;
    handler_id_i  <= hdl;
    period_i      <= per;
    repeat_req_i  <= rep;
    now_time_i    <= now;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic add_timer(logic [31:0] tag, logic present, logic [HANDLER_W-1:0] hdl,
                           logic [TIME_W-1:0] per, logic rep);
    issue(ACT_ADD, tag, present, hdl, per, rep, $urandom());
  endtask

  task automatic cancel_timer(logic [31:0] tag, logic present);
    issue(ACT_REMOVE, tag, present, 8'($urandom()), $urandom(), 1'($urandom_range(1)),
          $urandom());
  endtask

  task automatic tick_at(logic [TIME_W-1:0] now);
    issue(ACT_TICK, $urandom(), 1'($urandom_range(1)), 8'($urandom()), $urandom(),
          1'($urandom_range(1)), now);
  endtask

  // Run limit.
  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [31:0]       tag_pool [6];
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] per;
    int                phase_gap [4];
    int                pick;
    phase_gap = '{0, 53, 0, 35};
    tag_pool[0] = '0;
    for (int i = 1; i < 6; i++) tag_pool[i] = $urandom();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Rejects and misses on an empty table, and the unused code.
    cancel_timer($urandom(), 1'b0);
    cancel_timer(32'h1234_5678, 1'b1);
    issue(ACT_NONE, $urandom(), 1'b1, 8'h11, $urandom(), 1'b1, $urandom());
    add_timer(32'h0BAD_0BAD, 1'b1, 8'h00, 32'd5, 1'b0);

    // Field extremes; an add without a tag stores tag zero.
    add_timer($urandom(), 1'b0, 8'hFF, 32'h0000_0000, 1'b1);
    add_timer(32'hFFFF_FFFF, 1'b1, 8'h01, 32'hFFFF_FFFF, 1'b0);
    add_timer(32'h8000_0000, 1'b1, 8'h80, 32'h8000_0000, 1'b1);
    add_timer(32'h7FFF_FFFF, 1'b1, 8'h7F, 32'h7FFF_FFFF, 1'b0);
    tick_at(32'h0000_0000);
    cancel_timer(32'h0000_0000, 1'b1);

    // Refill the freed slots, then fill the table.
    add_timer(32'h0000_0001, 1'b1, 8'h55, 32'd1, 1'b1);
    add_timer(32'hAAAA_AAAA, 1'b1, 8'hAA, 32'd2, 1'b0);
    add_timer(32'h5555_5555, 1'b1, 8'h02, 32'd3, 1'b1);
    add_timer(32'hC3C3_C3C3, 1'b1, 8'h03, 32'd4, 1'b0);
    add_timer(32'h3C3C_3C3C, 1'b1, 8'h04, 32'd5, 1'b1);
    add_timer(32'h0F0F_0F0F, 1'b1, 8'h05, 32'd6, 1'b0);

    // Due test at the sign boundary, compaction and time wrap.
    tick_at(32'h7FFF_FFFF);
    cancel_timer(32'h8000_0000, 1'b1);
    cancel_timer(32'hFFFF_FFFF, 1'b1);
    tick_at(32'hFFFF_FFFF);
    cancel_timer(32'hFFFF_FFFF, 1'b1);
    tick_at(32'h0000_0004);

    // Random traffic in phases; the later half runs across the time wrap.
    now_ms = 32'h0000_0010;
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = phase_gap[ph];
      if (ph == 2) now_ms = 32'hFFFF_FF80;
      repeat (52) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          case ($urandom_range(9))
            0:       per = $urandom();
            1:       per = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h8000_0000;
            default: per = $urandom_range(40);
          endcase
          add_timer(tag_pool[$urandom_range(5)], ($urandom_range(7) != 0),
                    ($urandom_range(19) == 0) ? 8'h00 : 8'($urandom_range(255, 1)),
                    per, 1'($urandom_range(1)));
        end else if (pick < 65) begin
          cancel_timer(($urandom_range(7) == 0) ? $urandom() : tag_pool[$urandom_range(5)],
                       ($urandom_range(9) != 0));
        end else if (pick < 95) begin
          case ($urandom_range(11))
            0:       now_ms = $urandom();
            1:       now_ms = now_ms + 32'h8000_0000;
            default: now_ms = now_ms + $urandom_range(25);
          endcase
          tick_at(now_ms);
        end else begin
          issue(ACT_NONE, $urandom(), 1'($urandom_range(1)), 8'($urandom()), $urandom(),
                1'($urandom_range(1)), $urandom());
        end
      end
    end

    // Drain the remaining results, then give the verdict.
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/stt_pkg.sv
sv/stt_alu.sv
sv/stt_slot_store.sv
sv/software_timer_table_core.sv
sv/stt_checker.sv
tb/timer_table_checker.sv
tb/tb_top.sv
